// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the charge window controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define BCWC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define BCWC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BCWC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCWC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/core/bcwc_pkg.sv
package bcwc_pkg;

  localparam int unsigned TimerBitsDefault = 16;

  localparam int unsigned PctW     = 7;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StratW   = 2;
  localparam int unsigned TickCfgW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [OpW-1:0] OpEvent  = 2'd0;
  localparam logic [OpW-1:0] OpTick   = 2'd1;
  localparam logic [OpW-1:0] OpEnable = 2'd2;

  localparam logic [StratW-1:0] StratA = 2'd1;
  localparam logic [StratW-1:0] StratB = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgMinCharge  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxCharge  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStrategy   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartDelay = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLoopPeriod = 3'd4;

  localparam logic [TickCfgW-1:0] TickCfgReset = 16'd30;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_START,
    EV_STOP
  } event_e;

  typedef enum logic [1:0] {
    MODE_DEFAULT,
    MODE_ENABLED,
    MODE_DISABLED,
    MODE_BALANCE
  } mode_e;

  typedef struct packed {
    logic [PctW-1:0]     min_charge;
    logic [PctW-1:0]     max_charge;
    logic [StratW-1:0]   strategy_kind;
    logic [TickCfgW-1:0] start_delay;
    logic [TickCfgW-1:0] loop_period;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic            stop_event;
    logic            enable_value;
    logic [PctW-1:0] charge_percent;
  } req_t;

  typedef struct packed {
    logic   charger_on;
    logic   current_limited;
    mode_e  control_mode;
    event_e event_status;
    logic   timer_armed;
  } res_t;

endpackage

// File: rtl/core/battery_charge_window_controller.sv
// A request is captured in the input register, then its result in the result register.
// Throughput: one request per cycle while out_ready_i is high; each register holds one request.
// The state update for a request happens as it moves from the input to the result register.
// Reset (rst_ni low, asynchronous) clears both valid flags, loads the configuration defaults,
// and sets the control state to disabled, no event, default mode, charger on, unlimited.
`include "assert_macros.svh"

module battery_charge_window_controller
  import bcwc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic                stop_event_i,
  input  logic                enable_value_i,
  input  logic [PctW-1:0]     charge_percent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                charger_on_o,
  output logic                current_limited_o,
  output logic [1:0]          control_mode_o,
  output logic [1:0]          event_status_o,
  output logic                timer_armed_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  req_t req_q;
  res_t res_next, res_q;
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  bcwc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcwc_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .req_i    (req_q),
    .cfg_i    (cfg),
    .res_o    (res_next)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.operation      <= operation_i;
      req_q.stop_event     <= stop_event_i;
      req_q.enable_value   <= enable_value_i;
      req_q.charge_percent <= charge_percent_i;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign charger_on_o      = res_q.charger_on;
  assign current_limited_o = res_q.current_limited;
  assign control_mode_o    = res_q.control_mode;
  assign event_status_o    = res_q.event_status;
  assign timer_armed_o     = res_q.timer_armed;

  `BCWC_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_q |-> in_ready_o,
    "input stalled with an empty result register")
  `BCWC_ASSERT(a_result_after_commit, clk_i, rst_ni, advance |=> out_valid_q,
    "committed request produced no result")

endmodule

// File: rtl/core/bcwc_cfg_regs.sv
module bcwc_cfg_regs
  import bcwc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMinCharge:  cfg_d.min_charge    = cfg_data_i[PctW-1:0];
        CfgMaxCharge:  cfg_d.max_charge    = cfg_data_i[PctW-1:0];
        CfgStrategy:   cfg_d.strategy_kind = cfg_data_i[StratW-1:0];
        CfgStartDelay: cfg_d.start_delay   = cfg_data_i[TickCfgW-1:0];
        CfgLoopPeriod: cfg_d.loop_period   = cfg_data_i[TickCfgW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_charge    <= '0;
      cfg_q.max_charge    <= '0;
      cfg_q.strategy_kind <= '0;
      cfg_q.start_delay   <= TickCfgReset;
      cfg_q.loop_period   <= TickCfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/bcwc_ctrl.sv
`include "assert_macros.svh"

module bcwc_ctrl
  import bcwc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic commit_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic                  en_q, en_d;
  event_e                ev_q, ev_d;
  mode_e                 mode_q, mode_d;
  logic                  chg_q, chg_d;
  logic                  lim_q, lim_d;
  logic                  arm_q, arm_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;

  logic [31:0]           delay_ext, period_ext;
  logic [TIMER_BITS-1:0] delay_load, period_load;
  logic                  strat_on;

  assign delay_ext   = 32'(cfg_i.start_delay);
  assign period_ext  = 32'(cfg_i.loop_period);
  assign delay_load  = delay_ext[TIMER_BITS-1:0];
  assign period_load = period_ext[TIMER_BITS-1:0];
  assign strat_on    = (cfg_i.strategy_kind == StratA) || (cfg_i.strategy_kind == StratB);

  always_comb begin
    event_e new_ev;
    event_e apply_ev;
    logic   apply;
    en_d     = en_q;
    ev_d     = ev_q;
    mode_d   = mode_q;
    chg_d    = chg_q;
    lim_d    = lim_q;
    arm_d    = arm_q;
    cnt_d    = cnt_q;
    apply    = 1'b0;
    apply_ev = ev_q;
    new_ev   = req_i.stop_event ? EV_STOP : EV_START;

    case (req_i.operation)
      OpEvent: begin
        if (ev_q != new_ev) begin
          ev_d     = new_ev;
          apply    = 1'b1;
          apply_ev = new_ev;
        end
      end
      OpTick: begin
        if (arm_q) begin
          if (cnt_q <= TIMER_BITS'(1)) begin
            cnt_d = period_load;
            if (strat_on) begin
              if ((req_i.charge_percent > cfg_i.max_charge) && (mode_d != MODE_DISABLED)) begin
                chg_d  = 1'b0;
                lim_d  = 1'b1;
                mode_d = MODE_DISABLED;
              end
              if ((cfg_i.strategy_kind == StratB) &&
                  (req_i.charge_percent == cfg_i.max_charge) &&
                  (mode_d == MODE_DISABLED)) begin
                chg_d  = 1'b0;
                lim_d  = 1'b0;
                mode_d = MODE_BALANCE;
              end
              if ((req_i.charge_percent < cfg_i.min_charge) && (mode_d != MODE_ENABLED)) begin
                chg_d  = 1'b1;
                lim_d  = 1'b0;
                mode_d = MODE_ENABLED;
              end
            end
          end else begin
            cnt_d = cnt_q - TIMER_BITS'(1);
          end
        end
      end
      OpEnable: begin
        if (en_q != req_i.enable_value) begin
          en_d  = req_i.enable_value;
          apply = 1'b1;
        end
      end
      default: begin
        apply = 1'b0;
      end
    endcase

    // A start while enabled arms the delay; anything else cancels and restores defaults.
    if (apply) begin
      if (en_d && (apply_ev == EV_START)) begin
        arm_d = 1'b1;
        cnt_d = delay_load;
      end else begin
        if (en_d) begin
          ev_d = EV_NONE;
        end
        arm_d = 1'b0;
        if (mode_q != MODE_DEFAULT) begin
          mode_d = MODE_DEFAULT;
          chg_d  = 1'b1;
          lim_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      ev_q   <= EV_NONE;
      mode_q <= MODE_DEFAULT;
      chg_q  <= 1'b1;
      lim_q  <= 1'b0;
      arm_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (commit_i) begin
      en_q   <= en_d;
      ev_q   <= ev_d;
      mode_q <= mode_d;
      chg_q  <= chg_d;
      lim_q  <= lim_d;
      arm_q  <= arm_d;
      cnt_q  <= cnt_d;
    end
  end

  assign res_o.charger_on      = chg_d;
  assign res_o.current_limited = lim_d;
  assign res_o.control_mode    = mode_d;
  assign res_o.event_status    = ev_d;
  assign res_o.timer_armed     = arm_d;

  `BCWC_ASSERT(a_disarmed_when_off, clk_i, rst_ni, !en_q |-> !arm_q, "armed while disabled")
  `BCWC_ASSERT(a_armed_after_start, clk_i, rst_ni, arm_q |-> (ev_q == EV_START),
    "armed without start")
  `BCWC_ASSERT(a_charging_modes, clk_i, rst_ni,
    ((mode_q == MODE_DEFAULT) || (mode_q == MODE_ENABLED)) |-> (chg_q && !lim_q),
    "charging mode with charger off or current limited")
  `BCWC_ASSERT(a_disabled_mode, clk_i, rst_ni, (mode_q == MODE_DISABLED) |-> (!chg_q && lim_q),
    "disabled mode with charger on or current unlimited")

endmodule

// File: sim/battery_charge_window_controller_test.sv
`timescale 1ns / 100ps

module battery_charge_window_controller_test;
  import bcwc_pkg::*;

  localparam logic [OpW-1:0]    OpSpare    = 2'd3;
  localparam logic [StratW-1:0] StratNone  = 2'd0;
  localparam logic [StratW-1:0] StratSpare = 2'd3;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned RandomPhases  = 9;
  localparam int unsigned PhaseRequests = 125;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic [OpW-1:0]      operation_i      = OpEvent;
  logic                stop_event_i     = 1'b0;
  logic                enable_value_i   = 1'b0;
  logic [PctW-1:0]     charge_percent_i = '0;
  logic                out_ready_i      = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = CfgMinCharge;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       charger_on_o;
  logic       current_limited_o;
  logic [1:0] control_mode_o;
  logic [1:0] event_status_o;
  logic       timer_armed_o;

  battery_charge_window_controller u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .stop_event_i      (stop_event_i),
    .enable_value_i    (enable_value_i),
    .charge_percent_i  (charge_percent_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .charger_on_o      (charger_on_o),
    .current_limited_o (current_limited_o),
    .control_mode_o    (control_mode_o),
    .event_status_o    (event_status_o),
    .timer_armed_o     (timer_armed_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Our own copy of the controller state and its configuration.
  logic                        ctl_enable    = 1'b0;
  event_e                      ctl_event     = EV_NONE;
  mode_e                       ctl_mode      = MODE_DEFAULT;
  logic                        ctl_charger   = 1'b1;
  logic                        ctl_limit     = 1'b0;
  logic                        ctl_armed     = 1'b0;
  logic [TimerBitsDefault-1:0] ctl_countdown = '0;
  logic [PctW-1:0]             cfg_min       = '0;
  logic [PctW-1:0]             cfg_max       = '0;
  logic [StratW-1:0]           cfg_strategy  = StratNone;
  logic [TickCfgW-1:0]         cfg_delay     = TickCfgReset;
  logic [TickCfgW-1:0]         cfg_period    = TickCfgReset;

  req_t pending_requests[$];
  res_t expected_status[$];
  req_t offered_request;

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          calm_tail      = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned send_gap_pct   = 10;
  int unsigned stall_gap      = 0;
  int unsigned stall_pct      = 10;
  int unsigned hold_off       = 0;
  bit          hold_off_done  = 1'b0;

  function automatic void restore_defaults();
    if (ctl_mode != MODE_DEFAULT) begin
      ctl_mode    = MODE_DEFAULT;
      ctl_charger = 1'b1;
      ctl_limit   = 1'b0;
    end
  endfunction

  function automatic void apply_event(event_e ev);
    if (!ctl_enable) begin
      ctl_armed = 1'b0;
      restore_defaults();
    end else if (ev == EV_START) begin
      ctl_armed     = 1'b1;
      ctl_countdown = cfg_delay;
    end else begin
      ctl_event = EV_NONE;
      ctl_armed = 1'b0;
      restore_defaults();
    end
  endfunction

  function automatic res_t step_controller(req_t rq);
    event_e ev;
    res_t   r;
    case (rq.operation)
      OpEvent: begin
        ev = rq.stop_event ? EV_STOP : EV_START;
        if (ctl_event != ev) begin
          ctl_event = ev;
          apply_event(ev);
        end
      end
      OpTick: begin
        if (ctl_armed) begin
          if (ctl_countdown <= 1) begin
            if (cfg_strategy == StratA || cfg_strategy == StratB) begin
              if (rq.charge_percent > cfg_max && ctl_mode != MODE_DISABLED) begin
                ctl_charger = 1'b0;
                ctl_limit   = 1'b1;
                ctl_mode    = MODE_DISABLED;
              end
              if (cfg_strategy == StratB && rq.charge_percent == cfg_max &&
                  ctl_mode == MODE_DISABLED) begin
                ctl_charger = 1'b0;
                ctl_limit   = 1'b0;
                ctl_mode    = MODE_BALANCE;
              end
              if (rq.charge_percent < cfg_min && ctl_mode != MODE_ENABLED) begin
                ctl_charger = 1'b1;
                ctl_limit   = 1'b0;
                ctl_mode    = MODE_ENABLED;
              end
            end
            ctl_countdown = cfg_period;
          end else begin
            ctl_countdown = ctl_countdown - 1'b1;
          end
        end
      end
      OpEnable: begin
        if (ctl_enable != rq.enable_value) begin
          ctl_enable = rq.enable_value;
          apply_event(ctl_event);
        end
      end
      default: ;
    endcase
    r.charger_on      = ctl_charger;
    r.current_limited = ctl_limit;
    r.control_mode    = ctl_mode;
    r.event_status    = ctl_event;
    r.timer_armed     = ctl_armed;
    return r;
  endfunction

  function automatic req_t make_req(logic [OpW-1:0] op, logic stop, logic en,
                                    logic [PctW-1:0] charge);
    req_t rq;
    rq.operation      = op;
    rq.stop_event     = stop;
    rq.enable_value   = en;
    rq.charge_percent = charge;
    return rq;
  endfunction

  // Mostly ticks whose charge wanders slowly, so that it crosses the window edges,
  // with events, enable changes and unused operations mixed in.
  function automatic req_t random_request(inout int level);
    req_t        rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    level = level + int'($urandom_range(0, 6)) - 3;
    if (level < 0) level = 0;
    if (level > 100) level = 100;
    if (pick == 99) level = int'($urandom_range(0, 100));
    rq = make_req(OpTick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  PctW'(level));
    if (pick < 4) begin
      rq.charge_percent = PctW'($urandom_range(0, 127));
    end else if (pick >= 72 && pick < 84) begin
      rq.operation = OpEvent;
    end else if (pick >= 84 && pick < 90) begin
      rq.operation    = OpEnable;
      rq.enable_value = ($urandom_range(0, 3) != 0);
    end else if (pick >= 90 && pick < 95) begin
      rq.operation      = OpSpare;
      rq.charge_percent = PctW'($urandom_range(0, 127));
    end
    return rq;
  endfunction

  function automatic int unsigned pick_gap_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic check_field(string field, logic [1:0] want_v, logic [1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMinCharge:  cfg_min      = value[PctW-1:0];
      CfgMaxCharge:  cfg_max      = value[PctW-1:0];
      CfgStrategy:   cfg_strategy = value[StratW-1:0];
      CfgStartDelay: cfg_delay    = value[TickCfgW-1:0];
      CfgLoopPeriod: cfg_period   = value[TickCfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure_phase(int unsigned lo, int unsigned hi, logic [StratW-1:0] strat,
                                 int unsigned delay, int unsigned period);
    wait_until_drained();
    repeat (3) @(posedge clk_i);
    write_register(CfgMinCharge, CfgDataW'(lo));
    write_register(CfgMaxCharge, CfgDataW'(hi));
    write_register(CfgStrategy, CfgDataW'(strat));
    write_register(CfgStartDelay, CfgDataW'(delay));
    write_register(CfgLoopPeriod, CfgDataW'(period));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_status.push_back(step_controller(offered_request));
      if (!in_valid_i || in_ready_o) begin
        if ($urandom_range(0, 63) == 0) send_gap_pct = pick_gap_rate();
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0 && !calm_tail &&
                     $urandom_range(0, 99) < send_gap_pct) begin
          send_gap = $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          offered_request = pending_requests.pop_front();
          in_valid_i       <= 1'b1;
          operation_i      <= offered_request.operation;
          stop_event_i     <= offered_request.stop_event;
          enable_value_i   <= offered_request.enable_value;
          charge_percent_i <= offered_request.charge_percent;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          $error("Result arrived with no request outstanding.");
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("charger_on", want.charger_on, charger_on_o);
          check_field("current_limited", want.current_limited, current_limited_o);
          check_field("control_mode", want.control_mode, control_mode_o);
          check_field("event_status", want.event_status, event_status_o);
          check_field("timer_armed", want.timer_armed, timer_armed_o);
        end
      end
      if ($urandom_range(0, 63) == 0) stall_pct = pick_gap_rate();
      // Once a long backlog is queued, hold the result side off so the input stalls.
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else if (!hold_off_done && pending_requests.size() > 40) begin
        hold_off      = HoldOffCycles;
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          level;
    int unsigned lo;
    int unsigned hi;
    int unsigned delay;
    int unsigned period;
    logic [StratW-1:0] strat;
    level = 50;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: no strategy, window control disabled.
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpSpare, 1'b1, 1'b1, 7'd127));
    pending_requests.push_back(make_req(OpEvent, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpEvent, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpEvent, 1'b1, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b1, 7'd0));
    pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b1, 7'd0));
    pending_requests.push_back(make_req(OpEvent, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd50));
    pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b0, 7'd0));

    // Strategy B with a zero start delay: walk through every mode.
    configure_phase(20, 80, StratB, 0, 1);
    pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b1, 7'd0));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd127));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd80));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd81));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd50));
    pending_requests.push_back(make_req(OpEvent, 1'b1, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpEvent, 1'b1, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd90));
    pending_requests.push_back(make_req(OpEvent, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpTick, 1'b0, 1'b0, 7'd100));
    pending_requests.push_back(make_req(OpSpare, 1'b0, 1'b0, 7'd0));
    pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b0, 7'd0));

    for (int p = 0; p < RandomPhases; p++) begin
      lo     = $urandom_range(0, 100);
      hi     = $urandom_range(0, 100);
      strat  = StratW'($urandom_range(1, 2));
      delay  = $urandom_range(0, 4);
      period = $urandom_range(0, 3);
      case (p)
        0: begin
          lo = 0; hi = 100; strat = StratA; delay = 1; period = 1;
        end
        1: begin
          lo = 100; hi = 0; strat = StratB; delay = 0; period = 0;
        end
        2: strat = StratSpare;
        3: begin
          lo = 30; hi = 70; delay = 65535; period = 65535;
        end
        4: strat = StratNone;
        default: ;
      endcase
      configure_phase(lo, hi, strat, delay, period);
      if (p == RandomPhases - 1) calm_tail = 1'b1;
      pending_requests.push_back(make_req(OpEnable, 1'b0, 1'b1, PctW'(level)));
      pending_requests.push_back(make_req(OpEvent, 1'b0, 1'b1, PctW'(level)));
      repeat (PhaseRequests) pending_requests.push_back(random_request(level));
    end

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
